// ----- rtl/core/hbcd_pkg.sv -----
`timescale 1ns / 1ps
package hbcd_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int BUCKETS_DEF = 13;
	localparam logic [7:0] REFS_MAX = 8'hFF;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_UNDER  = 2'd2,
		ST_OVER   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_HIT,
		S_VIC,
		S_RD,
		S_RDW,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  device;
		logic [31:0] block;
		logic [4:0]  slot;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		logic       needs_read;
		status_t    status;
	} rsp_t;

	typedef struct packed {
		logic        loaded;
		logic [7:0]  refs;
		logic [7:0]  device;
		logic [31:0] block;
		logic [31:0] stamp;
		logic [31:0] order;
	} entry_t;

endpackage

// ----- rtl/core/hbcd_ram.sv -----
`timescale 1ns / 1ps
module hbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/hbcd_mod.sv -----
`timescale 1ns / 1ps
module hbcd_mod #(
	parameter int BUCKETS = hbcd_pkg::BUCKETS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [31:0]                                   value,
	output logic                                          done,
	output logic [$clog2(BUCKETS > 1 ? BUCKETS : 2)-1:0]  rem
);
	localparam int BW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
	localparam int LG = $clog2(BUCKETS);
	localparam int KS = 31 + LG;
	localparam logic [31:0] RECIP   = 32'((64'd1 << KS) / 64'(BUCKETS));
	localparam logic [31:0] DIVISOR = 32'(BUCKETS);

	logic          vld_s1, vld_s2, vld_s3;
	logic [31:0]   val_s1, val_s2;
	logic [63:0]   prod_s2;
	logic [BW:0]   diff_s3;
	logic [BW-1:0] r_q;
	logic          done_q;
	logic [31:0]   quo;
	logic [31:0]   back;
	logic [BW-1:0] rn;

	// estimate the quotient from the reciprocal product, then correct once
	always_comb begin
		quo  = 32'(prod_s2 >> KS);
		back = quo * DIVISOR;
		if (diff_s3 >= (BW+1)'(BUCKETS)) begin
			rn = BW'(diff_s3 - (BW+1)'(BUCKETS));
		end else begin
			rn = BW'(diff_s3);
		end
	end

	// advance the valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// multiply, subtract, correct
	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= value;
		end
		if (vld_s1) begin
			val_s2  <= val_s1;
			prod_s2 <= {32'd0, val_s1} * {32'd0, RECIP};
		end
		if (vld_s2) begin
			diff_s3 <= (BW+1)'(val_s2 - back);
		end
		if (vld_s3) begin
			r_q <= rn;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rem) < 32'(BUCKETS))) else $error("remainder out of range");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done) else $error("remainder not ready in time");
endmodule

// ----- rtl/core/hashed_block_cache_directory.sv -----
`timescale 1ns / 1ps
// A get finds its home bucket in the reciprocal remainder unit, then scans the allocated
// entries for a hit and, on a full miss, scans every entry for a victim, then finishes;
// release, pin and unpin read their slot and then finish.
// One item is taken at a time and only in the idle state, so a new request waits until
// the last one has finished; a stalled result holds the finish state.
// The entry RAM is scanned one word per cycle through its single read port.
// Reset clears counters and control; the entry RAM is not cleared (fill count gates it).
module hashed_block_cache_directory #(
	parameter int ENTRIES = hbcd_pkg::ENTRIES_DEF,
	parameter int BUCKETS = hbcd_pkg::BUCKETS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  hbcd_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output hbcd_pkg::rsp_t  rsp
);
	import hbcd_pkg::*;

	localparam int BW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
	localparam int IW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
	localparam int AW = $clog2(ENTRIES + 1);
	localparam int EW = $bits(entry_t) + BW;

	state_t        state_q, state_d;
	req_t          req_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic [AW-1:0] alloc_q;
	logic [31:0]   ic_q;
	logic [BW-1:0] home_q;

	logic [AW-1:0] cnt_q;
	logic          pend_q;
	logic [IW-1:0] cmp_q;
	logic          hit_q, vic_q;
	logic [IW-1:0] sel_q;
	entry_t        ent_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] bd_q;

	logic          mod_start, mod_done;
	logic [BW-1:0] mod_rem;
	logic          ram_re, ram_we;
	logic [IW-1:0] ram_raddr, ram_waddr;
	logic [EW-1:0] ram_rdata, ram_wdata;
	entry_t        rd_ent;
	logic [BW-1:0] rd_bkt;

	logic          scanning, scan_end, issue;
	logic [AW-1:0] limit;
	logic [BW-1:0] bkt_dist;
	logic          hit_match, vic_better;
	logic          out_free, accept;

	logic          fin_we, alloc_inc, ic_inc;
	logic [IW-1:0] fin_addr;
	entry_t        fin_ent;
	logic [BW-1:0] fin_bkt;
	rsp_t          fin_rsp;
	logic          slot_ok;

	hbcd_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (req.block),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	hbcd_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ent    = entry_t'(ram_rdata[EW-1:BW]);
	assign rd_bkt    = ram_rdata[BW-1:0];
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// scan control shared by hit and victim passes
	assign scanning = (state_q == S_HIT) || (state_q == S_VIC);
	assign limit    = (state_q == S_HIT) ? alloc_q : AW'(ENTRIES);
	assign issue    = scanning && (cnt_q < limit);
	assign scan_end = scanning && !issue && !pend_q;

	// cyclic bucket distance from home
	always_comb begin
		if (rd_bkt >= home_q) begin
			bkt_dist = rd_bkt - home_q;
		end else begin
			bkt_dist = BW'({1'b0, rd_bkt} + (BW+1)'(BUCKETS) - {1'b0, home_q});
		end
	end

	assign hit_match = pend_q && (state_q == S_HIT) && !hit_q &&
		(rd_ent.device == req_q.device) && (rd_ent.block == req_q.block);
	assign vic_better = pend_q && (state_q == S_VIC) && (rd_ent.refs == 8'd0) &&
		(!vic_q || (bkt_dist < bd_q) || ((bkt_dist == bd_q) &&
		((rd_ent.stamp < ent_q.stamp) ||
		((rd_ent.stamp == ent_q.stamp) && (rd_ent.order > ent_q.order)))));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (req.command == CMD_GET) ? S_MOD : S_RD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_d = S_HIT;
				end
			end
			S_HIT: begin
				if (scan_end) begin
					state_d = (hit_q || alloc_q < AW'(ENTRIES)) ? S_FIN : S_VIC;
				end
			end
			S_VIC: begin
				if (scan_end) begin
					state_d = S_FIN;
				end
			end
			S_RD:  state_d = S_RDW;
			S_RDW: state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// finishing decision for the current item
	always_comb begin
		fin_we    = 1'b0;
		fin_addr  = sel_q;
		fin_ent   = ent_q;
		fin_bkt   = bkt_q;
		fin_rsp   = '0;
		alloc_inc = 1'b0;
		ic_inc    = 1'b0;
		slot_ok   = (6'(req_q.slot) < 6'(alloc_q));
		case (req_q.command)
			CMD_GET: begin
				if (hit_q) begin
					fin_rsp.slot_out = 5'(sel_q);
					fin_rsp.hit      = 1'b1;
					if (ent_q.refs == REFS_MAX) begin
						fin_rsp.status = ST_OVER;
					end else begin
						fin_we             = 1'b1;
						fin_ent.refs       = ent_q.refs + 8'd1;
						fin_ent.loaded     = 1'b1;
						fin_rsp.needs_read = !ent_q.loaded;
					end
				end else if (alloc_q < AW'(ENTRIES)) begin
					fin_we             = 1'b1;
					fin_addr           = alloc_q[IW-1:0];
					fin_ent.loaded     = 1'b1;
					fin_ent.refs       = 8'd1;
					fin_ent.device     = req_q.device;
					fin_ent.block      = req_q.block;
					fin_ent.stamp      = '0;
					fin_ent.order      = ic_q;
					fin_bkt            = home_q;
					fin_rsp.slot_out   = 5'(alloc_q);
					fin_rsp.needs_read = 1'b1;
					alloc_inc          = 1'b1;
					ic_inc             = 1'b1;
				end else if (vic_q) begin
					fin_we             = 1'b1;
					fin_ent.loaded     = 1'b1;
					fin_ent.refs       = 8'd1;
					fin_ent.device     = req_q.device;
					fin_ent.block      = req_q.block;
					fin_bkt            = home_q;
					if (bkt_q != home_q) begin
						fin_ent.order = ic_q;
						ic_inc        = 1'b1;
					end
					fin_rsp.slot_out   = 5'(sel_q);
					fin_rsp.needs_read = 1'b1;
				end else begin
					fin_rsp.status = ST_NOFREE;
				end
			end
			default: begin
				fin_rsp.slot_out = req_q.slot;
				if (!slot_ok) begin
					fin_rsp.status = ST_UNDER;
				end else if (req_q.command == CMD_PIN) begin
					if (ent_q.refs == REFS_MAX) begin
						fin_rsp.status = ST_OVER;
					end else begin
						fin_we       = 1'b1;
						fin_ent.refs = ent_q.refs + 8'd1;
					end
				end else if (ent_q.refs == 8'd0) begin
					fin_rsp.status = ST_UNDER;
				end else begin
					fin_we       = 1'b1;
					fin_ent.refs = ent_q.refs - 8'd1;
					if (req_q.command == CMD_RELEASE && ent_q.refs == 8'd1) begin
						fin_ent.stamp = req_q.now;
					end
				end
			end
		endcase
	end

	// memory and unit controls
	always_comb begin
		mod_start = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = cnt_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = fin_addr;
		ram_wdata = {fin_ent, fin_bkt};
		unique case (state_q)
			S_IDLE: mod_start = accept && (req.command == CMD_GET);
			S_HIT, S_VIC: ram_re = issue;
			S_RD: begin
				ram_re    = 1'b1;
				ram_raddr = req_q.slot[IW-1:0];
			end
			S_FIN: ram_we = fin_we && out_free;
			default: ram_re = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			alloc_q     <= '0;
			ic_q        <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			hit_q       <= 1'b0;
			vic_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
				hit_q  <= 1'b0;
				vic_q  <= 1'b0;
			end else if (scanning) begin
				pend_q <= issue;
				if (issue) begin
					cnt_q <= cnt_q + AW'(1);
				end
				if (scan_end) begin
					cnt_q <= '0;
				end
				if (hit_match) begin
					hit_q <= 1'b1;
				end
				if (vic_better) begin
					vic_q <= 1'b1;
				end
			end
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
				if (alloc_inc) begin
					alloc_q <= alloc_q + AW'(1);
				end
				if (ic_inc) begin
					ic_q <= ic_q + 32'd1;
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_MOD && mod_done) begin
			home_q <= mod_rem;
		end
		if (scanning && issue) begin
			cmp_q <= cnt_q[IW-1:0];
		end
		if (hit_match || vic_better) begin
			sel_q <= cmp_q;
			ent_q <= rd_ent;
			bkt_q <= rd_bkt;
			bd_q  <= bkt_dist;
		end
		if (state_q == S_RDW) begin
			sel_q <= req_q.slot[IW-1:0];
			ent_q <= rd_ent;
			bkt_q <= rd_bkt;
		end
		if (state_q == S_FIN && out_free) begin
			rsp_q <= fin_rsp;
		end
	end

	a_alloc_max: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= AW'(ENTRIES)) else $error("fill count beyond depth");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (state_q == S_IDLE && rsp_valid_q))
		else $error("finish did not post a result");
	a_victim_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VIC) |-> (alloc_q == AW'(ENTRIES) && !hit_q))
		else $error("victim scan without full miss");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FIN)) else $error("entry write outside finish");
endmodule
